>>> sv/lbec_pkg.sv
`timescale 1ns / 1ps
package lbec_pkg;

   localparam int COUNT_WIDTH_DEF   = 24;
   localparam int SYMBOL_CODES_DEF  = 64;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int CODE_W      = 6;
   localparam int LOG_FRAC    = 24;
   localparam int LOG_W       = 29;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int CNT_OUT_W   = 24;
   localparam int ENT_OUT_W   = 19;

   localparam logic [7:0] BYTE_CYR_LO = 8'd192;
   localparam logic [7:0] BYTE_TAB    = 8'd9;
   localparam logic [7:0] BYTE_VT     = 8'd11;
   localparam logic [7:0] BYTE_FF     = 8'd12;
   localparam logic [7:0] BYTE_CR     = 8'd13;
   localparam logic [7:0] BYTE_SPACE  = 8'd32;

   localparam logic [CODE_W-1:0] CODE_TAB   = 6'd32;
   localparam logic [CODE_W-1:0] CODE_VT    = 6'd33;
   localparam logic [CODE_W-1:0] CODE_FF    = 6'd34;
   localparam logic [CODE_W-1:0] CODE_CR    = 6'd35;
   localparam logic [CODE_W-1:0] CODE_SPACE = 6'd36;

   typedef struct packed {
      logic              kept;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] prev;
      logic              has_pair;
      logic              disjoint;
      logic              last;
   } op_type;

   typedef struct packed {
      logic                 empty_text;
      logic [ENT_OUT_W-1:0] disjoint_entropy;
      logic [ENT_OUT_W-1:0] overlapping_entropy;
      logic [ENT_OUT_W-1:0] letter_entropy;
      logic [CNT_OUT_W-1:0] disjoint_total;
      logic [CNT_OUT_W-1:0] overlapping_total;
      logic [CNT_OUT_W-1:0] kept_length;
   } result_type;

   typedef enum logic [1:0] {TBL_SYM, TBL_OVL, TBL_DIS} table_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_RD, ST_UPD, ST_LD_START, ST_LD_WAIT, ST_W_RD, ST_W_DATA,
      ST_W_LOG, ST_W_ACC, ST_DIV_START, ST_DIV_WAIT, ST_ROUND, ST_OUT
   } back_state_type;

   typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQ} log_state_type;

   typedef enum logic {DV_IDLE, DV_RUN} div_state_type;

endpackage

>>> sv/letter_bigram_entropy_counter_top.sv
`timescale 1ns / 1ps
// Counts letters of a cp1251 text and reports single-letter and letter-pair entropies.
// Each request carries one text byte on req_tdata, with req_tlast on the final byte.
// A front stage filters and classifies bytes at one per cycle into a four-entry queue,
// unless the queue is full or the memories are still being cleared. The back stage
// updates the count memories with a read and then a write for each kept symbol, and
// the queue absorbs short bursts. On the final byte the back stage walks all three
// tables, clearing them as it goes: it takes the logarithm of the table total and of
// each nonzero entry, then divides the sum by a nonzero total, and one response appears.
// Each response holds the counts and three entropies, with empty_text on rsp_tuser.
// A response waits in its output register until rsp_tready, and requests still flow
// in meanwhile; only the next final byte waits for the register to drain.
// After reset the block clears its letter and pair memories, SYMBOL_CODES squared
// addresses (4096 by default), with req_tready low; csr_we writes keep_spaces at any time.
module letter_bigram_entropy_counter_top import lbec_pkg::*; #(
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
   parameter int SYMBOL_CODES  = SYMBOL_CODES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // text_byte
   input  logic         req_tlast,  // end_of_text
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // kept_length, overlapping_total, disjoint_total, letter_entropy,
   // overlapping_entropy, disjoint_entropy
   output logic [135:0] rsp_tdata,
   output logic         rsp_tuser,  // empty_text
   input  logic         csr_we,
   input  logic         csr_wdata
);

   logic       keep_spaces_ff, keep_spaces_in;
   logic       push, pop, full, empty, init_busy;
   op_type     push_op, head_op;
   result_type rsp_data;

   assign keep_spaces_in = csr_we ? csr_wdata : keep_spaces_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_spaces_ff <= 1'b1;
      end else begin
         keep_spaces_ff <= keep_spaces_in;
      end
   end

   lbec_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_byte    (req_tdata),
      .req_last    (req_tlast),
      .keep_spaces (keep_spaces_ff),
      .hold        (init_busy),
      .full        (full),
      .ready       (req_tready),
      .push        (push),
      .push_op     (push_op)
   );

   lbec_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .pop_op  (head_op),
      .full    (full),
      .empty   (empty)
   );

   lbec_back #(
      .COUNT_WIDTH   (COUNT_WIDTH),
      .SYMBOL_CODES  (SYMBOL_CODES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head_op   (head_op),
      .pop       (pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {7'b0, rsp_data.disjoint_entropy, rsp_data.overlapping_entropy,
                       rsp_data.letter_entropy, rsp_data.disjoint_total,
                       rsp_data.overlapping_total, rsp_data.kept_length};
   assign rsp_tuser = rsp_data.empty_text;

endmodule

>>> sv/lbec_front.sv
`timescale 1ns / 1ps
module lbec_front import lbec_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   input  logic       keep_spaces,
   input  logic       hold,
   input  logic       full,
   output logic       ready,
   output logic       push,
   output op_type     push_op
);

   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] kept_ff, kept_in;
   logic [CODE_W-1:0]      last_sym_ff, last_sym_in;
   logic                   last_blank_ff, last_blank_in;
   logic                   keep, blank, accept;
   logic [CODE_W-1:0]      code;

   assign ready  = !full && !hold;
   assign accept = req_valid && ready;

   always_comb begin
      keep  = 1'b0;
      blank = 1'b0;
      code  = '0;
      if (req_byte >= BYTE_CYR_LO) begin
         keep = 1'b1;
         code = {1'b0, req_byte[4:0]};
      end else if (keep_spaces && !last_blank_ff) begin
         blank = 1'b1;
         unique case (req_byte)
            BYTE_TAB: begin
               keep = 1'b1;
               code = CODE_TAB;
            end
            BYTE_VT: begin
               keep = 1'b1;
               code = CODE_VT;
            end
            BYTE_FF: begin
               keep = 1'b1;
               code = CODE_FF;
            end
            BYTE_CR: begin
               keep = 1'b1;
               code = CODE_CR;
            end
            BYTE_SPACE: begin
               keep = 1'b1;
               code = CODE_SPACE;
            end
            default: begin
               keep = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      push_op.kept     = keep;
      push_op.code     = code;
      push_op.prev     = last_sym_ff;
      push_op.has_pair = (kept_ff != '0);
      push_op.disjoint = kept_ff[0];
      push_op.last     = req_last;
      push          = accept && (keep || req_last);
      kept_in       = kept_ff;
      last_sym_in   = last_sym_ff;
      last_blank_in = last_blank_ff;
      if (accept && keep) begin
         kept_in       = (kept_ff == CMAX) ? kept_ff : kept_ff + 1'b1;
         last_sym_in   = code;
         last_blank_in = blank;
      end
      if (accept && req_last) begin
         kept_in       = '0;
         last_sym_in   = '0;
         last_blank_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff       <= '0;
         last_sym_ff   <= '0;
         last_blank_ff <= 1'b0;
      end else begin
         kept_ff       <= kept_in;
         last_sym_ff   <= last_sym_in;
         last_blank_ff <= last_blank_in;
      end
   end

endmodule

>>> sv/lbec_fifo.sv
`timescale 1ns / 1ps
module lbec_fifo import lbec_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output op_type pop_op,
   output logic   full,
   output logic   empty
);

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW:0]   wr_ff, wr_in, rd_ff, rd_in;

   assign empty  = (wr_ff == rd_ff);
   assign full   = (wr_ff[QUEUE_AW] != rd_ff[QUEUE_AW]) &&
                   (wr_ff[QUEUE_AW-1:0] == rd_ff[QUEUE_AW-1:0]);
   assign pop_op = entry_ff[rd_ff[QUEUE_AW-1:0]];
   assign wr_in  = (push && !full) ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = (pop && !empty) ? rd_ff + 1'b1 : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ff[QUEUE_AW-1:0]] <= push_op;
      end
   end

endmodule

>>> sv/lbec_log2.sv
`timescale 1ns / 1ps
module lbec_log2 import lbec_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      x,
   output logic             done,
   output logic [LOG_W-1:0] result
);

   log_state_type    state_ff, state_in;
   logic [31:0]      m_ff;
   logic [4:0]       k_ff, cnt_ff;
   logic [LOG_W-1:0] r_ff;
   logic             done_ff;
   logic [63:0]      prod;
   logic [32:0]      sq;
   logic [31:0]      m_next;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LG_IDLE: if (start) state_in = LG_NORM;
         LG_NORM: if (m_ff[31]) state_in = LG_SQ;
         LG_SQ:   if (cnt_ff == '0) state_in = LG_IDLE;
         default: state_in = LG_IDLE;
      endcase
   end

   always_comb begin
      prod   = m_ff * m_ff;
      sq     = prod[63:31];
      m_next = sq[32] ? sq[32:1] : sq[31:0];
      done   = done_ff;
      result = r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == LG_SQ) && (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         LG_IDLE: begin
            m_ff <= x;
            k_ff <= 5'd31;
         end
         LG_NORM: begin
            if (m_ff[31]) begin
               r_ff   <= {k_ff, {LOG_FRAC{1'b0}}};
               cnt_ff <= 5'(LOG_FRAC - 1);
            end else begin
               m_ff <= {m_ff[30:0], 1'b0};
               k_ff <= k_ff - 1'b1;
            end
         end
         LG_SQ: begin
            m_ff         <= m_next;
            r_ff[cnt_ff] <= sq[32];
            cnt_ff       <= cnt_ff - 1'b1;
         end
         default: begin
            m_ff <= m_ff;
         end
      endcase
   end

endmodule

>>> sv/lbec_div.sv
`timescale 1ns / 1ps
module lbec_div import lbec_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            dividend,
   input  logic [COUNT_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [63:0]            quotient
);

   div_state_type          state_ff, state_in;
   logic [63:0]            q_ff;
   logic [COUNT_WIDTH-1:0] rem_ff, d_ff;
   logic [5:0]             cnt_ff;
   logic                   done_ff;
   logic [COUNT_WIDTH:0]   shifted, diff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DV_IDLE: if (start) state_in = DV_RUN;
         DV_RUN:  if (cnt_ff == '0) state_in = DV_IDLE;
         default: state_in = DV_IDLE;
      endcase
   end

   always_comb begin
      shifted  = {rem_ff, q_ff[63]};
      diff     = shifted - {1'b0, d_ff};
      done     = done_ff;
      quotient = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == DV_RUN) && (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == DV_IDLE) begin
         if (start) begin
            q_ff   <= dividend;
            d_ff   <= divisor;
            rem_ff <= '0;
            cnt_ff <= 6'd63;
         end
      end else begin
         cnt_ff <= cnt_ff - 1'b1;
         if (shifted >= {1'b0, d_ff}) begin
            rem_ff <= diff[COUNT_WIDTH-1:0];
            q_ff   <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted[COUNT_WIDTH-1:0];
            q_ff   <= {q_ff[62:0], 1'b0};
         end
      end
   end

endmodule

>>> sv/lbec_back.sv
`timescale 1ns / 1ps
module lbec_back import lbec_pkg::*; #(
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
   parameter int SYMBOL_CODES  = SYMBOL_CODES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  op_type     head_op,
   output logic       pop,
   output logic       init_busy,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   localparam int PAIRS   = SYMBOL_CODES * SYMBOL_CODES;
   localparam int PAIR_AW = $clog2(PAIRS);
   localparam int TW      = COUNT_WIDTH + LOG_W;
   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
   localparam logic [63:0] LIM6    = 64'd6 << FRACTION_BITS;
   localparam logic [63:0] ENT_LIM = (LIM6 > 64'h7FFFF) ? 64'h7FFFF : LIM6;
   localparam logic [4:0]  BASE_SH = 5'(LOG_FRAC - FRACTION_BITS);

   logic [COUNT_WIDTH-1:0] sym_mem [SYMBOL_CODES];
   logic [COUNT_WIDTH-1:0] ovl_mem [PAIRS];
   logic [COUNT_WIDTH-1:0] dis_mem [PAIRS];

   back_state_type         state_ff, state_in;
   table_type              tsel_ff;
   op_type                 op_ff;
   logic [PAIR_AW-1:0]     addr_ff;
   logic [COUNT_WIDTH-1:0] kept_ff, ovl_ff, dis_ff;
   logic [COUNT_WIDTH-1:0] sym_rd_ff, ovl_rd_ff, dis_rd_ff, cval_ff;
   logic [LOG_W-1:0]       ld_ff;
   logic [TW-1:0]          t_ff;
   logic [63:0]            acc_ff;
   logic [ENT_OUT_W-1:0]   ent_ff [3];
   logic                   rsp_valid_ff;
   result_type             rsp_ff;

   logic                   sym_we, ovl_we, dis_we;
   logic [CODE_W-1:0]      sym_wa, sym_ra;
   logic [PAIR_AW-1:0]     pair_wa, pair_ra, pair_idx;
   logic [COUNT_WIDTH-1:0] sym_wd, ovl_wd, dis_wd;
   logic                   log_start, log_done, div_start, div_done;
   logic [31:0]            log_x;
   logic [LOG_W-1:0]       log_r, diff;
   logic [63:0]            quot, rounded, limited;
   logic [64:0]            acc_sum;
   logic [4:0]             sh;
   logic [COUNT_WIDTH-1:0] denom, rdata, clamped;
   logic                   last_addr, need_log;
   logic [31:0]            kept32, ovl32, dis32;

   assign pair_idx = PAIR_AW'(op_ff.prev) * PAIR_AW'(SYMBOL_CODES) + PAIR_AW'(op_ff.code);

   always_comb begin
      unique case (tsel_ff)
         TBL_SYM: begin
            denom     = kept_ff;
            rdata     = sym_rd_ff;
            last_addr = (addr_ff == PAIR_AW'(SYMBOL_CODES - 1));
         end
         TBL_OVL: begin
            denom     = ovl_ff;
            rdata     = ovl_rd_ff;
            last_addr = (addr_ff == PAIR_AW'(PAIRS - 1));
         end
         default: begin
            denom     = dis_ff;
            rdata     = dis_rd_ff;
            last_addr = (addr_ff == PAIR_AW'(PAIRS - 1));
         end
      endcase
      clamped  = (rdata > denom) ? denom : rdata;
      need_log = (rdata != '0) && (denom != '0);
      diff     = (log_r < ld_ff) ? ld_ff - log_r : '0;
      acc_sum  = {1'b0, acc_ff} + 65'(t_ff);
      sh       = BASE_SH + ((tsel_ff == TBL_SYM) ? 5'd0 : 5'd1);
      rounded  = quot >> sh;
      if (sh != 5'd0) begin
         rounded = rounded + 64'((quot >> (sh - 5'd1)) & 64'd1);
      end
      limited = (rounded > ENT_LIM) ? ENT_LIM : rounded;
      if (denom == '0) begin
         limited = '0;
      end
      kept32 = 32'(kept_ff);
      ovl32  = 32'(ovl_ff);
      dis32  = 32'(dis_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:      if (addr_ff == PAIR_AW'(PAIRS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (!empty) begin
               state_in = head_op.kept ? ST_RD : ST_LD_START;
            end
         end
         ST_RD:        state_in = ST_UPD;
         ST_UPD:       state_in = op_ff.last ? ST_LD_START : ST_IDLE;
         ST_LD_START:  state_in = (denom != '0) ? ST_LD_WAIT : ST_W_RD;
         ST_LD_WAIT:   if (log_done) state_in = ST_W_RD;
         ST_W_RD:      state_in = ST_W_DATA;
         ST_W_DATA: begin
            if (need_log) begin
               state_in = ST_W_LOG;
            end else begin
               state_in = last_addr ? ST_DIV_START : ST_W_RD;
            end
         end
         ST_W_LOG:     if (log_done) state_in = ST_W_ACC;
         ST_W_ACC:     state_in = last_addr ? ST_DIV_START : ST_W_RD;
         ST_DIV_START: state_in = (denom != '0) ? ST_DIV_WAIT : ST_ROUND;
         ST_DIV_WAIT:  if (div_done) state_in = ST_ROUND;
         ST_ROUND:     state_in = (tsel_ff == TBL_DIS) ? ST_OUT : ST_LD_START;
         ST_OUT:       if (!rsp_valid_ff) state_in = ST_IDLE;
         default:      state_in = ST_INIT;
      endcase
   end

   always_comb begin
      sym_we    = 1'b0;
      ovl_we    = 1'b0;
      dis_we    = 1'b0;
      sym_wa    = addr_ff[CODE_W-1:0];
      pair_wa   = addr_ff;
      sym_wd    = '0;
      ovl_wd    = '0;
      dis_wd    = '0;
      sym_ra    = addr_ff[CODE_W-1:0];
      pair_ra   = addr_ff;
      pop       = 1'b0;
      log_start = 1'b0;
      log_x     = 32'(denom);
      div_start = 1'b0;
      init_busy = (state_ff == ST_INIT);
      unique case (state_ff)
         ST_INIT: begin
            sym_we = (addr_ff < PAIR_AW'(SYMBOL_CODES));
            ovl_we = 1'b1;
            dis_we = 1'b1;
         end
         ST_IDLE: begin
            pop = !empty;
         end
         ST_RD: begin
            sym_ra  = op_ff.code;
            pair_ra = pair_idx;
         end
         ST_UPD: begin
            sym_wa  = op_ff.code;
            pair_wa = pair_idx;
            sym_we  = 1'b1;
            sym_wd  = (sym_rd_ff == CMAX) ? sym_rd_ff : sym_rd_ff + 1'b1;
            ovl_we  = op_ff.has_pair;
            ovl_wd  = (ovl_rd_ff == CMAX) ? ovl_rd_ff : ovl_rd_ff + 1'b1;
            dis_we  = op_ff.has_pair && op_ff.disjoint;
            dis_wd  = (dis_rd_ff == CMAX) ? dis_rd_ff : dis_rd_ff + 1'b1;
         end
         ST_LD_START: begin
            log_start = (denom != '0);
         end
         ST_W_DATA: begin
            sym_we    = (tsel_ff == TBL_SYM);
            ovl_we    = (tsel_ff == TBL_OVL);
            dis_we    = (tsel_ff == TBL_DIS);
            log_start = need_log;
            log_x     = 32'(clamped);
         end
         ST_DIV_START: begin
            div_start = (denom != '0);
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_wa] <= sym_wd;
      end
      sym_rd_ff <= sym_mem[sym_ra];
   end

   always_ff @(posedge clock) begin
      if (ovl_we) begin
         ovl_mem[pair_wa] <= ovl_wd;
      end
      ovl_rd_ff <= ovl_mem[pair_ra];
   end

   always_ff @(posedge clock) begin
      if (dis_we) begin
         dis_mem[pair_wa] <= dis_wd;
      end
      dis_rd_ff <= dis_mem[pair_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         tsel_ff      <= TBL_SYM;
         kept_ff      <= '0;
         ovl_ff       <= '0;
         dis_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               addr_ff <= (addr_ff == PAIR_AW'(PAIRS - 1)) ? '0 : addr_ff + 1'b1;
            end
            ST_IDLE: begin
               tsel_ff <= TBL_SYM;
            end
            ST_UPD: begin
               kept_ff <= (kept_ff == CMAX) ? kept_ff : kept_ff + 1'b1;
               if (op_ff.has_pair) begin
                  ovl_ff <= (ovl_ff == CMAX) ? ovl_ff : ovl_ff + 1'b1;
               end
               if (op_ff.has_pair && op_ff.disjoint) begin
                  dis_ff <= (dis_ff == CMAX) ? dis_ff : dis_ff + 1'b1;
               end
            end
            ST_LD_START: begin
               addr_ff <= '0;
            end
            ST_W_DATA: begin
               if (!need_log) begin
                  addr_ff <= last_addr ? '0 : addr_ff + 1'b1;
               end
            end
            ST_W_ACC: begin
               addr_ff <= last_addr ? '0 : addr_ff + 1'b1;
            end
            ST_ROUND: begin
               unique case (tsel_ff)
                  TBL_SYM: tsel_ff <= TBL_OVL;
                  TBL_OVL: tsel_ff <= TBL_DIS;
                  default: tsel_ff <= TBL_DIS;
               endcase
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  kept_ff      <= '0;
                  ovl_ff       <= '0;
                  dis_ff       <= '0;
               end
            end
            default: begin
               addr_ff <= addr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && !empty) begin
         op_ff <= head_op;
      end
      if (state_ff == ST_LD_START) begin
         acc_ff <= '0;
      end
      if (state_ff == ST_LD_WAIT && log_done) begin
         ld_ff <= log_r;
      end
      if (state_ff == ST_W_DATA) begin
         cval_ff <= clamped;
      end
      if (state_ff == ST_W_LOG && log_done) begin
         t_ff <= TW'(cval_ff) * TW'(diff);
      end
      if (state_ff == ST_W_ACC) begin
         acc_ff <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
      end
      if (state_ff == ST_ROUND) begin
         ent_ff[tsel_ff] <= limited[ENT_OUT_W-1:0];
      end
      if (state_ff == ST_OUT && !rsp_valid_ff) begin
         rsp_ff.kept_length         <= kept32[CNT_OUT_W-1:0];
         rsp_ff.overlapping_total   <= ovl32[CNT_OUT_W-1:0];
         rsp_ff.disjoint_total      <= dis32[CNT_OUT_W-1:0];
         rsp_ff.letter_entropy      <= ent_ff[TBL_SYM];
         rsp_ff.overlapping_entropy <= ent_ff[TBL_OVL];
         rsp_ff.disjoint_entropy    <= ent_ff[TBL_DIS];
         rsp_ff.empty_text          <= (kept_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lbec_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_r)
   );

   lbec_div #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (denom),
      .done     (div_done),
      .quotient (quot)
   );

endmodule

>>> sv/lbec_checker.sv
`timescale 1ns / 1ps
module lbec_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tuser
);

   // The memories are cleared after reset, so no request is taken at first.
   a_no_req_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // An empty text has no counts and no entropy.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[128:0] == 129'd0)
      else $error("empty text carries nonzero fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind letter_bigram_entropy_counter_top lbec_checker u_lbec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> dv/tb_letter_bigram_entropy_counter_top.sv
`timescale 1ns / 1ps
module tb_letter_bigram_entropy_counter_top;
   import lbec_pkg::*;

   localparam int          SYM_N      = SYMBOL_CODES_DEF;
   localparam int          PAIR_N     = SYM_N * SYM_N;
   localparam int unsigned CNT_MAX    = (1 << COUNT_WIDTH_DEF) - 1;
   localparam int          WATCHDOG   = 200000;
   localparam int          SETTLE     = 200;
   localparam logic [7:0]  BYTE_LF    = 8'd10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [135:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic         csr_wdata = 1'b0;

   letter_bigram_entropy_counter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   logic        mdl_keep_spaces = 1'b1;
   int unsigned letter_counts [SYM_N];
   int unsigned overlap_pairs [PAIR_N];
   int unsigned disjoint_pairs [PAIR_N];
   int unsigned kept_total, overlap_total, disjoint_total;
   logic [5:0]  prev_code;
   logic        prev_blank;

   result_type  pending_results[$];
   int          errors = 0;
   int          texts_sent = 0;
   int          results_seen = 0;
   int          bytes_sent = 0;
   int          empty_seen = 0;
   bit          sender_idles = 1'b0;
   bit          receiver_stalls = 1'b0;
   int          quiet_cycles = 0;

   function automatic int unsigned sat_inc(int unsigned v);
      return (v < CNT_MAX) ? v + 1 : v;
   endfunction

   function automatic void clear_text_stats();
      foreach (letter_counts[i]) letter_counts[i] = 0;
      foreach (overlap_pairs[i]) overlap_pairs[i] = 0;
      foreach (disjoint_pairs[i]) disjoint_pairs[i] = 0;
      kept_total = 0;
      overlap_total = 0;
      disjoint_total = 0;
      prev_code = '0;
      prev_blank = 1'b0;
   endfunction

   function automatic longint unsigned log2_q24(int unsigned x);
      int unsigned       k = 0;
      longint unsigned   m, r;
      while (k < 31 && (x >> (k + 1)) != 0) k++;
      m = longint'(x) << (31 - k);
      r = longint'(k) << LOG_FRAC;
      for (int i = LOG_FRAC - 1; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            r = r | (64'd1 << i);
         end
      end
      return r;
   endfunction

   function automatic logic [ENT_OUT_W-1:0] table_entropy(table_type tbl, int unsigned total);
      longint unsigned ld, acc, lc, t, q, r;
      int unsigned     c, s;
      int              n;
      if (total == 0) return '0;
      acc = 0;
      ld = log2_q24(total);
      n = (tbl == TBL_SYM) ? SYM_N : PAIR_N;
      for (int i = 0; i < n; i++) begin
         c = (tbl == TBL_SYM) ? letter_counts[i] :
             (tbl == TBL_OVL) ? overlap_pairs[i] : disjoint_pairs[i];
         if (c == 0) continue;
         if (c > total) c = total;
         lc = log2_q24(c);
         t = (lc < ld) ? longint'(c) * (ld - lc) : 64'd0;
         acc = (acc > ~t) ? ~64'd0 : acc + t;
      end
      q = acc / total;
      s = LOG_FRAC - FRACTION_BITS_DEF + ((tbl == TBL_SYM) ? 0 : 1);
      r = (q >> s) + ((q >> (s - 1)) & 1);
      if (r > (64'd6 << FRACTION_BITS_DEF)) r = 64'd6 << FRACTION_BITS_DEF;
      return r[ENT_OUT_W-1:0];
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      logic       kept = 1'b0;
      logic       blank = 1'b0;
      logic [5:0] code = '0;
      result_type res;
      if (b >= BYTE_CYR_LO) begin
         kept = 1'b1;
         code = {1'b0, b[4:0]};
      end else if (mdl_keep_spaces && !prev_blank) begin
         blank = 1'b1;
         kept = 1'b1;
         case (b)
            BYTE_TAB:   code = CODE_TAB;
            BYTE_VT:    code = CODE_VT;
            BYTE_FF:    code = CODE_FF;
            BYTE_CR:    code = CODE_CR;
            BYTE_SPACE: code = CODE_SPACE;
            default:    kept = 1'b0;
         endcase
      end
      if (kept) begin
         letter_counts[code] = sat_inc(letter_counts[code]);
         if (kept_total > 0) begin
            overlap_pairs[prev_code * SYM_N + code] =
               sat_inc(overlap_pairs[prev_code * SYM_N + code]);
            overlap_total = sat_inc(overlap_total);
            if (kept_total[0]) begin
               disjoint_pairs[prev_code * SYM_N + code] =
                  sat_inc(disjoint_pairs[prev_code * SYM_N + code]);
               disjoint_total = sat_inc(disjoint_total);
            end
         end
         kept_total = sat_inc(kept_total);
         prev_code = code;
         prev_blank = blank;
      end
      if (last) begin
         res.kept_length = kept_total[CNT_OUT_W-1:0];
         res.overlapping_total = overlap_total[CNT_OUT_W-1:0];
         res.disjoint_total = disjoint_total[CNT_OUT_W-1:0];
         res.letter_entropy = table_entropy(TBL_SYM, kept_total);
         res.overlapping_entropy = table_entropy(TBL_OVL, overlap_total);
         res.disjoint_entropy = table_entropy(TBL_DIS, disjoint_total);
         res.empty_text = (kept_total == 0);
         pending_results.push_back(res);
         clear_text_stats();
      end
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      @(negedge clock);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_byte(b, last);
      bytes_sent++;
      if (last) texts_sent++;
   endtask

   task automatic release_bus();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
   endtask

   task automatic wait_for_results();
      release_bus();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_keep_spaces(logic v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      mdl_keep_spaces = v;
   endtask

   function automatic logic [7:0] random_text_byte();
      int sel = $urandom_range(0, 99);
      if (sel < 60) return 8'($urandom_range(192, 255));
      if (sel < 85) begin
         case ($urandom_range(0, 5))
            0: return BYTE_TAB;
            1: return BYTE_VT;
            2: return BYTE_FF;
            3: return BYTE_CR;
            4: return BYTE_LF;
            default: return BYTE_SPACE;
         endcase
      end
      return 8'($urandom_range(0, 191));
   endfunction

   task automatic send_random_text(int len);
      for (int i = 0; i < len; i++) send_byte(random_text_byte(), i == len - 1);
   endtask

   task automatic test_directed();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(BYTE_SPACE, 1'b0);
      send_byte(BYTE_SPACE, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(BYTE_TAB, 1'b0);
      send_byte(BYTE_VT, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(BYTE_FF, 1'b0);
      send_byte(BYTE_LF, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(BYTE_LF, 1'b1);
      wait_for_results();
      write_keep_spaces(1'b0);
      send_byte(BYTE_SPACE, 1'b0);
      send_byte(8'hC1, 1'b0);
      send_byte(BYTE_TAB, 1'b0);
      send_byte(8'hE1, 1'b0);
      send_byte(8'hF5, 1'b1);
      send_byte(BYTE_SPACE, 1'b1);
      wait_for_results();
   endtask

   task automatic test_mode_switch_mid_text();
      send_byte(8'hE2, 1'b0);
      send_byte(BYTE_SPACE, 1'b0);
      send_byte(8'hE3, 1'b0);
      wait_for_results();
      write_keep_spaces(1'b1);
      send_byte(BYTE_SPACE, 1'b0);
      send_byte(8'hE4, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      wait_for_results();
      write_keep_spaces(1'b0);
      send_byte(BYTE_TAB, 1'b0);
      send_byte(8'hC5, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_texts(int n_bytes);
      int sent = 0;
      int len;
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      while (sent < n_bytes) begin
         if (sent > n_bytes * 4 / 5) begin
            sender_idles = 1'b0;
            receiver_stalls = 1'b0;
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 14);
         send_random_text(len);
         sent += len;
         if ($urandom_range(0, 5) == 0) begin
            wait_for_results();
            write_keep_spaces(1'($urandom_range(0, 1)));
         end
      end
      wait_for_results();
   endtask

   initial begin
      clear_text_stats();
      forever begin
         @(negedge clock);
         if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[128:0]};
         results_seen++;
         if (got.empty_text) empty_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected response %h", got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.kept_length !== want.kept_length) begin
               $error("kept_length exp %0d got %0d", want.kept_length, got.kept_length);
               errors++;
            end
            if (got.overlapping_total !== want.overlapping_total) begin
               $error("overlapping_total exp %0d got %0d",
                      want.overlapping_total, got.overlapping_total);
               errors++;
            end
            if (got.disjoint_total !== want.disjoint_total) begin
               $error("disjoint_total exp %0d got %0d",
                      want.disjoint_total, got.disjoint_total);
               errors++;
            end
            if (got.letter_entropy !== want.letter_entropy) begin
               $error("letter_entropy exp %0d got %0d",
                      want.letter_entropy, got.letter_entropy);
               errors++;
            end
            if (got.overlapping_entropy !== want.overlapping_entropy) begin
               $error("overlapping_entropy exp %0d got %0d",
                      want.overlapping_entropy, got.overlapping_entropy);
               errors++;
            end
            if (got.disjoint_entropy !== want.disjoint_entropy) begin
               $error("disjoint_entropy exp %0d got %0d",
                      want.disjoint_entropy, got.disjoint_entropy);
               errors++;
            end
            if (got.empty_text !== want.empty_text) begin
               $error("empty_text exp %0d got %0d", want.empty_text, got.empty_text);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("letter_bigram_entropy_counter_top regression: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_mode_switch_mid_text();
      test_random_texts(400);
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         errors++;
      end
      $display("Sent %0d bytes in %0d texts; checked %0d responses, %0d of them empty.",
               bytes_sent, texts_sent, results_seen, empty_seen);
      if (errors == 0) begin
         $display("letter_bigram_entropy_counter_top regression: pass");
      end else begin
         $display("letter_bigram_entropy_counter_top regression: fail");
      end
      $finish;
   end

endmodule

>>> letter_bigram_entropy_counter_top.f
sv/lbec_pkg.sv
sv/lbec_front.sv
sv/lbec_fifo.sv
sv/lbec_log2.sv
sv/lbec_div.sv
sv/lbec_back.sv
sv/letter_bigram_entropy_counter_top.sv
sv/lbec_checker.sv
dv/tb_letter_bigram_entropy_counter_top.sv
